[rtl/lorentz_boost_four_vector_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the four-vector boost
// Shared wrappers around concurrent assertions, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef LORENTZ_BOOST_FOUR_VECTOR_ASSERT_SVH
`define LORENTZ_BOOST_FOUR_VECTOR_ASSERT_SVH

// checked only while out of reset
`define LBFV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define LBFV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lbfv_pkg.sv]
// ----------------------------------------------------------------------------
// lbfv_pkg
// Types and constants shared by the four-vector boost modules.
// ----------------------------------------------------------------------------
package lbfv_pkg;

   localparam int VALUE_WIDTH = 32;   // saturation range of the results
   localparam int MASS_W      = 31;
   localparam int DOT_W       = 36;   // beta.p, Q20.16
   localparam int EDIFF_W     = 37;   // E - beta.p

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BETA_ONE  = 2'd1;
   localparam logic [1:0] ST_BETA_OVER = 2'd2;
   localparam logic [1:0] ST_SAT       = 2'd3;

   localparam logic [63:0]        ONE_Q60 = 64'h1000_0000_0000_0000;
   localparam logic [63:0]        ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic signed [63:0] C_LIMIT = 64'sh4000_0000_0000_0000;

   localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (VALUE_WIDTH - 1)) - 128'sd1;
   localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;
   localparam logic [31:0]         RAIL_HI = SAT_HI[31:0];
   localparam logic [31:0]         RAIL_LO = SAT_LO[31:0];

   typedef struct packed {
      logic                      bypass;
      logic [1:0]                status;
      logic signed [31:0]        energy;
      logic signed [31:0]        mom_x;
      logic signed [31:0]        mom_y;
      logic signed [31:0]        mom_z;
      logic signed [31:0]        vel_x;
      logic signed [31:0]        vel_y;
      logic signed [31:0]        vel_z;
      logic [MASS_W-1:0]         mass;
      logic signed [DOT_W-1:0]   dot;
      logic signed [EDIFF_W-1:0] ediff;
   } ctx_type;

   typedef struct packed {
      ctx_type     ctx;
      logic [63:0] rad;     // 16 (1 - beta^2), Q4.60 scaled
   } queue_type;

   typedef struct packed {
      ctx_type     ctx;
      logic [63:0] g;       // gamma, Q32.32
   } ctxg_type;

   typedef struct packed {
      ctx_type            ctx;
      logic signed [31:0] energy;
      logic               esat;
   } tail_type;

endpackage

[rtl/lbfv_isqrt.sv]
// ----------------------------------------------------------------------------
// lbfv_isqrt
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module lbfv_isqrt #(
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [63:0]   in_rad,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [31:0]   out_root,
   output logic [PW-1:0] out_pay
);
   localparam int STEPS = 32;

   logic [STEPS-1:0] v_ff;
   logic [63:0]      x_ff   [STEPS];
   logic [63:0]      r_ff   [STEPS];
   logic [PW-1:0]    pay_ff [STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[STEPS-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0]   x_prev, r_prev, trial, x_in, r_in;
      logic [PW-1:0] pay_prev;

      if (k == 0) begin : g_first
         assign x_prev   = in_rad;
         assign r_prev   = '0;
         assign pay_prev = in_pay;
      end else begin : g_next
         assign x_prev   = x_ff[k-1];
         assign r_prev   = r_ff[k-1];
         assign pay_prev = pay_ff[k-1];
      end

      always_comb begin
         trial = r_prev + BIT;
         if (x_prev >= trial) begin
            x_in = x_prev - trial;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            x_in = x_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[k]   <= x_in;
         r_ff[k]   <= r_in;
         pay_ff[k] <= pay_prev;
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_root  = r_ff[STEPS-1][31:0];
   assign out_pay   = pay_ff[STEPS-1];

endmodule

[rtl/lbfv_div.sv]
// ----------------------------------------------------------------------------
// lbfv_div
// Pipelined restoring divide, 128-bit by 64-bit, one quotient bit per stage.
// The high numerator word must be below the divisor.
// ----------------------------------------------------------------------------
module lbfv_div #(
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [63:0]   in_hi,
   input  logic [63:0]   in_lo,
   input  logic [63:0]   in_den,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [63:0]   out_quo,
   output logic [PW-1:0] out_pay
);
   localparam int STEPS = 64;

   logic [STEPS-1:0] v_ff;
   logic [63:0]      rem_ff [STEPS];
   logic [63:0]      lo_ff  [STEPS];
   logic [63:0]      quo_ff [STEPS];
   logic [63:0]      den_ff [STEPS];
   logic [PW-1:0]    pay_ff [STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[STEPS-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [63:0]   rem_prev, lo_prev, quo_prev, den_prev;
      logic [63:0]   rem_in, quo_in;
      logic [64:0]   trial;
      logic [PW-1:0] pay_prev;

      if (k == 0) begin : g_first
         assign rem_prev = in_hi;
         assign lo_prev  = in_lo;
         assign quo_prev = '0;
         assign den_prev = in_den;
         assign pay_prev = in_pay;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign lo_prev  = lo_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign pay_prev = pay_ff[k-1];
      end

      always_comb begin
         trial = {rem_prev, lo_prev[63]};
         if (trial >= {1'b0, den_prev}) begin
            rem_in = 64'(trial - {1'b0, den_prev});
            quo_in = {quo_prev[62:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_prev[62:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         lo_ff[k]  <= {lo_prev[62:0], 1'b0};
         quo_ff[k] <= quo_in;
         den_ff[k] <= den_prev;
         pay_ff[k] <= pay_prev;
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_pay   = pay_ff[STEPS-1];

endmodule

[rtl/lbfv_mul.sv]
// ----------------------------------------------------------------------------
// lbfv_mul
// Signed 64x64 multiply, 128-bit product, four stages, 32-bit partials.
// ----------------------------------------------------------------------------
module lbfv_mul #(
   parameter int LANES = 1,
   parameter int PW    = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic signed [63:0]  in_a [LANES],
   input  logic signed [63:0]  in_b [LANES],
   input  logic [PW-1:0]       in_pay,
   output logic                out_valid,
   output logic signed [127:0] out_prod [LANES],
   output logic [PW-1:0]       out_pay
);
   localparam int STAGES = 4;

   logic [STAGES-1:0] v_ff;
   logic [PW-1:0]     pay_ff [STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      pay_ff[0] <= in_pay;
      for (int s = 1; s < STAGES; s++) begin
         pay_ff[s] <= pay_ff[s-1];
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [2:0]          neg_ff;
      logic [63:0]         ma_ff, mb_ff, ma_in, mb_in;
      logic [63:0]         pp_ff [4];
      logic [127:0]        sum_ff, sum_in;
      logic signed [127:0] prod_ff;

      always_comb begin
         ma_in  = in_a[l][63] ? -in_a[l] : in_a[l];
         mb_in  = in_b[l][63] ? -in_b[l] : in_b[l];
         sum_in = {64'b0, pp_ff[0]} + {32'b0, pp_ff[1], 32'b0}
                + {32'b0, pp_ff[2], 32'b0} + {pp_ff[3], 64'b0};
      end

      always_ff @(posedge clock) begin
         neg_ff   <= {neg_ff[1:0], in_a[l][63] ^ in_b[l][63]};
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
         pp_ff[0] <= ma_ff[31:0]  * mb_ff[31:0];
         pp_ff[1] <= ma_ff[31:0]  * mb_ff[63:32];
         pp_ff[2] <= ma_ff[63:32] * mb_ff[31:0];
         pp_ff[3] <= ma_ff[63:32] * mb_ff[63:32];
         sum_ff   <= sum_in;
         prod_ff  <= neg_ff[2] ? -sum_ff : sum_ff;
      end

      assign out_prod[l] = prod_ff;
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_pay   = pay_ff[STAGES-1];

endmodule

[rtl/lbfv_queue.sv]
// ----------------------------------------------------------------------------
// lbfv_queue
// Two-entry hand-off queue between front end and back end.
// ----------------------------------------------------------------------------
module lbfv_queue #(
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [PW-1:0] push_data,
   output logic          out_valid,
   output logic [PW-1:0] out_data,
   output logic          full
);
   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   logic [PW-1:0]  slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             pop;

   // back end never stalls: pop whenever something is held
   assign pop       = (cnt_ff != '0);
   assign out_valid = pop;
   assign out_data  = slot_ff[rd_ff];
   assign full      = (cnt_ff == (PTR_W + 1)'(DEPTH));

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[rtl/lbfv_front.sv]
// ----------------------------------------------------------------------------
// lbfv_front
// Front end: beta squared, beta.p and item classification, three stages.
// ----------------------------------------------------------------------------
module lbfv_front
   import lbfv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] vel_x,
   input  logic signed [31:0] vel_y,
   input  logic signed [31:0] vel_z,
   input  logic signed [31:0] energy,
   input  logic signed [31:0] mom_x,
   input  logic signed [31:0] mom_y,
   input  logic signed [31:0] mom_z,
   input  logic [MASS_W-1:0]  mass,
   output logic               out_valid,
   output queue_type          out_item
);
   logic [2:0]         v_ff;
   ctx_type            c1_ff, c1_in, c2_ff, c3_in;
   logic [63:0]        sq_ff [3];
   logic signed [63:0] dp_ff [3];
   logic [63:0]        b2_ff, b2_in, diff;
   logic signed [65:0] dot_ff, dot_in;
   queue_type          q3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   // stage 1: capture and form the six products
   always_comb begin
      c1_in        = '0;
      c1_in.energy = energy;
      c1_in.mom_x  = mom_x;
      c1_in.mom_y  = mom_y;
      c1_in.mom_z  = mom_z;
      c1_in.vel_x  = vel_x;
      c1_in.vel_y  = vel_y;
      c1_in.vel_z  = vel_z;
      c1_in.mass   = mass;
   end

   always_ff @(posedge clock) begin
      c1_ff    <= c1_in;
      sq_ff[0] <= vel_x * vel_x;
      sq_ff[1] <= vel_y * vel_y;
      sq_ff[2] <= vel_z * vel_z;
      dp_ff[0] <= vel_x * mom_x;
      dp_ff[1] <= vel_y * mom_y;
      dp_ff[2] <= vel_z * mom_z;
   end

   // stage 2: sums
   always_comb begin
      b2_in  = sq_ff[0] + sq_ff[1] + sq_ff[2];
      dot_in = 66'(dp_ff[0]) + 66'(dp_ff[1]) + 66'(dp_ff[2]);
   end

   always_ff @(posedge clock) begin
      c2_ff  <= c1_ff;
      b2_ff  <= b2_in;
      dot_ff <= dot_in;
   end

   // stage 3: classify, radicand, E - beta.p
   always_comb begin
      c3_in       = c2_ff;
      c3_in.dot   = dot_ff[65:30];
      c3_in.ediff = EDIFF_W'(c2_ff.energy) - EDIFF_W'(c3_in.dot);
      c3_in.bypass = (b2_ff >= ONE_Q60) || (b2_ff == '0);
      if (b2_ff == ONE_Q60) begin
         c3_in.status = ST_BETA_ONE;
      end else if (b2_ff > ONE_Q60) begin
         c3_in.status = ST_BETA_OVER;
      end else begin
         c3_in.status = ST_OK;
      end
      diff = ONE_Q60 - b2_ff;
   end

   always_ff @(posedge clock) begin
      q3_ff.ctx <= c3_in;
      q3_ff.rad <= {diff[59:0], 4'b0000};
   end

   assign out_valid = v_ff[2];
   assign out_item  = q3_ff;

endmodule

[rtl/lbfv_back.sv]
// ----------------------------------------------------------------------------
// lbfv_back
// Back end: gamma, (gamma-1)/beta^2, boosted energy and momentum, saturation.
// ----------------------------------------------------------------------------
module lbfv_back
   import lbfv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  queue_type          in_item,
   output logic               out_valid,
   output logic signed [31:0] energy_out,
   output logic signed [31:0] mom_x_out,
   output logic signed [31:0] mom_y_out,
   output logic signed [31:0] mom_z_out,
   output logic [1:0]         status
);
   localparam int CTX_W  = $bits(ctx_type);
   localparam int CTXG_W = $bits(ctxg_type);
   localparam int TAIL_W = $bits(tail_type);

   logic     va, vb, vc, vd, ve, vs;
   ctx_type  ctx_a, ctx_b, ctx_e;
   ctxg_type cg_b, cg_c, cg_d;
   tail_type tail_ff, tail_in, tail_s;
   logic [31:0] root;
   logic [63:0] g_q, k_q;

   logic signed [63:0]  gsq_a  [1];
   logic signed [127:0] gsq_p  [1];
   logic signed [63:0]  term_a [3];
   logic signed [63:0]  term_b [3];
   logic signed [127:0] term_p [3];
   logic signed [63:0]  scl_a  [3];
   logic signed [63:0]  scl_b  [3];
   logic signed [127:0] scl_p  [3];

   logic signed [95:0]  e_sh, e_clip, c_sh;
   logic signed [127:0] c_acc;
   logic signed [63:0]  c_ff, c_in;
   logic                vd_ff, vf_ff;

   logic signed [97:0]  m_sum [3];
   logic [31:0]         m_q   [3];
   logic [2:0]          m_sat;
   logic signed [31:0]  mom_in [3];

   logic signed [31:0] e_out_ff, mx_out_ff, my_out_ff, mz_out_ff;
   logic [1:0]         st_out_ff;

   // square root of 16 (1 - beta^2): 2^32 sqrt(1 - beta^2)
   lbfv_isqrt #(.PW(CTX_W)) u_root (
      .clock, .reset,
      .in_valid (in_valid),
      .in_rad   (in_item.rad),
      .in_pay   (in_item.ctx),
      .out_valid(va),
      .out_root (root),
      .out_pay  (ctx_a)
   );

   // gamma = 2^64 / root, Q32.32
   lbfv_div #(.PW(CTX_W)) u_gamma (
      .clock, .reset,
      .in_valid (va),
      .in_hi    (64'd1),
      .in_lo    (64'd0),
      .in_den   ({32'b0, root}),
      .in_pay   (ctx_a),
      .out_valid(vb),
      .out_quo  (g_q),
      .out_pay  (ctx_b)
   );

   assign gsq_a[0] = g_q;
   assign cg_b.ctx = ctx_b;
   assign cg_b.g   = g_q;

   lbfv_mul #(.LANES(1), .PW(CTXG_W)) u_gsq (
      .clock, .reset,
      .in_valid (vb),
      .in_a     (gsq_a),
      .in_b     (gsq_a),
      .in_pay   (cg_b),
      .out_valid(vc),
      .out_prod (gsq_p),
      .out_pay  (cg_c)
   );

   // K = gamma^2 / (gamma + 1) = (gamma - 1) / beta^2
   lbfv_div #(.PW(CTXG_W)) u_kdiv (
      .clock, .reset,
      .in_valid (vc),
      .in_hi    (gsq_p[0][127:64]),
      .in_lo    (gsq_p[0][63:0]),
      .in_den   (cg_c.g + ONE_Q32),
      .in_pay   (cg_c),
      .out_valid(vd),
      .out_quo  (k_q),
      .out_pay  (cg_d)
   );

   // lanes: K*D, G*E, G*(E - D)
   always_comb begin
      term_a[0] = k_q;
      term_b[0] = 64'(cg_d.ctx.dot);
      term_a[1] = cg_d.g;
      term_b[1] = 64'(cg_d.ctx.energy);
      term_a[2] = cg_d.g;
      term_b[2] = 64'(cg_d.ctx.ediff);
   end

   lbfv_mul #(.LANES(3), .PW(CTX_W)) u_terms (
      .clock, .reset,
      .in_valid (vd),
      .in_a     (term_a),
      .in_b     (term_b),
      .in_pay   (cg_d.ctx),
      .out_valid(ve),
      .out_prod (term_p),
      .out_pay  (ctx_e)
   );

   // energy clamp and saturation, momentum coefficient C
   always_comb begin
      e_sh = term_p[2][127:32];
      if (e_sh < $signed({65'b0, ctx_e.mass})) begin
         e_clip = $signed({65'b0, ctx_e.mass});
      end else begin
         e_clip = e_sh;
      end
      tail_in.ctx = ctx_e;
      if (e_clip > SAT_HI) begin
         tail_in.energy = RAIL_HI;
         tail_in.esat   = 1'b1;
      end else begin
         tail_in.energy = e_clip[31:0];
         tail_in.esat   = 1'b0;
      end
      c_acc = term_p[0] - term_p[1];
      c_sh  = c_acc[127:32];
      if (c_sh > C_LIMIT) begin
         c_in = C_LIMIT;
      end else if (c_sh < -C_LIMIT) begin
         c_in = -C_LIMIT;
      end else begin
         c_in = c_sh[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else begin
         vd_ff <= ve;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
      c_ff    <= c_in;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         scl_a[i] = c_ff;
      end
      scl_b[0] = 64'(tail_ff.ctx.vel_x);
      scl_b[1] = 64'(tail_ff.ctx.vel_y);
      scl_b[2] = 64'(tail_ff.ctx.vel_z);
   end

   lbfv_mul #(.LANES(3), .PW(TAIL_W)) u_scale (
      .clock, .reset,
      .in_valid (vd_ff),
      .in_a     (scl_a),
      .in_b     (scl_b),
      .in_pay   (tail_ff),
      .out_valid(vs),
      .out_prod (scl_p),
      .out_pay  (tail_s)
   );

   // p' = C vel / 2^30 + p, saturated
   always_comb begin
      mom_in[0] = tail_s.ctx.mom_x;
      mom_in[1] = tail_s.ctx.mom_y;
      mom_in[2] = tail_s.ctx.mom_z;
      for (int i = 0; i < 3; i++) begin
         m_sum[i] = $signed(scl_p[i][127:30]) + 98'(mom_in[i]);
         if (m_sum[i] > SAT_HI) begin
            m_q[i]   = RAIL_HI;
            m_sat[i] = 1'b1;
         end else if (m_sum[i] < SAT_LO) begin
            m_q[i]   = RAIL_LO;
            m_sat[i] = 1'b1;
         end else begin
            m_q[i]   = m_sum[i][31:0];
            m_sat[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else begin
         vf_ff <= vs;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_s.ctx.bypass) begin
         e_out_ff  <= tail_s.ctx.energy;
         mx_out_ff <= tail_s.ctx.mom_x;
         my_out_ff <= tail_s.ctx.mom_y;
         mz_out_ff <= tail_s.ctx.mom_z;
         st_out_ff <= tail_s.ctx.status;
      end else begin
         e_out_ff  <= tail_s.energy;
         mx_out_ff <= m_q[0];
         my_out_ff <= m_q[1];
         mz_out_ff <= m_q[2];
         st_out_ff <= (tail_s.esat || (m_sat != '0)) ? ST_SAT : ST_OK;
      end
   end

   assign out_valid  = vf_ff;
   assign energy_out = e_out_ff;
   assign mom_x_out  = mx_out_ff;
   assign mom_y_out  = my_out_ff;
   assign mom_z_out  = mz_out_ff;
   assign status     = st_out_ff;

endmodule

[rtl/lorentz_boost_four_vector.sv]
// ----------------------------------------------------------------------------
// lorentz_boost_four_vector
// Fixed-point Lorentz boost of one four-momentum along an arbitrary velocity.
// ----------------------------------------------------------------------------
// Takes one item per clock: raise start with the fields and the item is taken
// at that edge unless busy is high. Its result appears for a single cycle
// with rsp_valid high; the receiver cannot hold it off, so it must capture
// it then. Each item passes the front end stages, the queue slot, a 32-stage
// square root, two 64-stage dividers (gamma, then (gamma-1)/beta^2), three
// 4-stage multipliers with a register ahead of the last, and the output register.
// Items are independent and fully pipelined, so results leave in input order at
// the same rate they enter. busy reflects a full hand-off queue between the front
// end and the back end; the back end drains it every cycle, so in steady use busy
// stays low. Beta squared of one or more, or zero, passes the input through with
// the matching status; any saturated result raises status 3.
// ----------------------------------------------------------------------------
module lorentz_boost_four_vector
   import lbfv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic signed [31:0] req_energy_in,
   input  logic signed [31:0] req_mom_x_in,
   input  logic signed [31:0] req_mom_y_in,
   input  logic signed [31:0] req_mom_z_in,
   input  logic [MASS_W-1:0]  req_rest_mass,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_energy_out,
   output logic signed [31:0] rsp_mom_x_out,
   output logic signed [31:0] rsp_mom_y_out,
   output logic signed [31:0] rsp_mom_z_out,
   output logic [1:0]         rsp_status
);
   logic      accept;
   logic      front_valid, queue_valid, queue_full;
   queue_type front_item, queue_item;

   assign accept = start && !queue_full;
   assign busy   = queue_full;

   // front end: products, beta^2, beta.p, classification
   lbfv_front u_front (
      .clock, .reset,
      .in_valid (accept),
      .vel_x    (req_vel_x),
      .vel_y    (req_vel_y),
      .vel_z    (req_vel_z),
      .energy   (req_energy_in),
      .mom_x    (req_mom_x_in),
      .mom_y    (req_mom_y_in),
      .mom_z    (req_mom_z_in),
      .mass     (req_rest_mass),
      .out_valid(front_valid),
      .out_item (front_item)
   );

   // hand-off between the two halves
   lbfv_queue #(.PW($bits(queue_type))) u_queue (
      .clock, .reset,
      .push     (front_valid),
      .push_data(front_item),
      .out_valid(queue_valid),
      .out_data (queue_item),
      .full     (queue_full)
   );

   // back end: gamma, boost, saturation, output register
   lbfv_back u_back (
      .clock, .reset,
      .in_valid  (queue_valid),
      .in_item   (queue_item),
      .out_valid (rsp_valid),
      .energy_out(rsp_energy_out),
      .mom_x_out (rsp_mom_x_out),
      .mom_y_out (rsp_mom_y_out),
      .mom_z_out (rsp_mom_z_out),
      .status    (rsp_status)
   );

endmodule

[rtl/lbfv_checker.sv]
// ----------------------------------------------------------------------------
// lbfv_checker
// Port-level checks for the four-vector boost, bound to the top level.
// ----------------------------------------------------------------------------
`include "lorentz_boost_four_vector_assert.svh"

module lbfv_checker
   import lbfv_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_energy_out,
   input logic [31:0] rsp_mom_x_out,
   input logic [31:0] rsp_mom_y_out,
   input logic [31:0] rsp_mom_z_out,
   input logic [1:0]  rsp_status
);
   logic on_rail;

   assign on_rail = (rsp_energy_out == RAIL_HI)
                 || (rsp_mom_x_out == RAIL_HI) || (rsp_mom_x_out == RAIL_LO)
                 || (rsp_mom_y_out == RAIL_HI) || (rsp_mom_y_out == RAIL_LO)
                 || (rsp_mom_z_out == RAIL_HI) || (rsp_mom_z_out == RAIL_LO);

   // pipeline flushed by reset
   `LBFV_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_valid, "result right after reset")

   // back end drains the queue every cycle
   `LBFV_ASSERT(a_never_busy, clock, reset, start |-> !busy, "queue backed up")

   // a saturated item shows at least one output on a rail
   `LBFV_ASSERT(a_sat_on_rail, clock, reset, rsp_valid && rsp_status == ST_SAT |-> on_rail, "saturation flag without rail value")

endmodule

bind lorentz_boost_four_vector lbfv_checker u_lbfv_checker (.*);
